// File: design/dlmb_pkg.sv
package dlmb_pkg;

  localparam int DEPTH_BITS  = 24;
  localparam int MM_W        = 16;
  localparam int CFG_DIM_W   = 13;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int BOX_W       = 12;
  localparam int MAX_DIM_DEF = 4096;

  localparam int PROD_W = MM_W + DEPTH_BITS;
  localparam int DEN_W  = MM_W + DEPTH_BITS + 1;
  localparam int FN_W   = 2 * MM_W;
  localparam int NUM_W  = FN_W + DEPTH_BITS;
  localparam int FRAC_W = 7;
  localparam int CNT_W  = $clog2(MM_W);
  localparam int T_W    = MM_W + FRAC_W;

  // cutoff at 99 / 100 of far
  localparam int CUT_NUM = 99;
  localparam int CUT_DEN = 100;

  localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = CFG_DIM_W'(640);
  localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = CFG_DIM_W'(480);
  localparam logic [MM_W-1:0]      NEAR_RST   = MM_W'(100);
  localparam logic [MM_W-1:0]      FAR_RST    = MM_W'(10000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_NEAR_MM,
    REG_FAR_MM
  } cfg_reg_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_CALC,
    T_PIXEL,
    T_BOX
  } top_state_t;

  typedef enum logic [2:0] {
    D_IDLE,
    D_MULA,
    D_MULB,
    D_CHECK,
    D_QUO,
    D_FRAC_INIT,
    D_FRAC,
    D_FINAL
  } div_state_t;

  typedef struct packed {
    logic            done;
    logic            cut;
    logic [MM_W-1:0] depth;
  } div_res_t;

  typedef struct packed {
    logic step;
    logic masked;
  } frm_ctl_t;

  typedef struct packed {
    logic             found;
    logic [BOX_W-1:0] box_left;
    logic [BOX_W-1:0] box_right;
    logic [BOX_W-1:0] box_top;
    logic [BOX_W-1:0] box_bottom;
  } box_t;

endpackage

// File: design/dlmb_div.sv
module dlmb_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [dlmb_pkg::DEPTH_BITS-1:0] code,
  input  logic [dlmb_pkg::MM_W-1:0]       near_mm,
  input  logic [dlmb_pkg::MM_W-1:0]       far_mm,
  output dlmb_pkg::div_res_t              res
);
  import dlmb_pkg::*;

  div_state_t state_r, state_nxt;

  logic [DEPTH_BITS-1:0] code_r;
  logic                  far_ge_r;
  logic [PROD_W-1:0]     prod_r;
  logic [FN_W-1:0]       fn_r;
  logic [DEN_W-1:0]      den_r;
  logic [NUM_W-1:0]      rem_r;
  logic [NUM_W-1:0]      dsh_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [MM_W-1:0]       q_r;
  logic [FRAC_W-1:0]     a_r;
  logic                  round_r;
  logic                  cut_r;
  logic                  done_r;
  logic [MM_W-1:0]       depth_r;

  logic [MM_W-1:0]  span;
  logic [DEN_W-1:0] far_sc;
  logic [DEN_W-1:0] den_calc;
  logic             ovf;
  logic             take;
  logic [NUM_W-1:0] rem_sub;
  logic [DEN_W-1:0] r_low;
  logic [NUM_W-1:0] r_x100;
  logic             rnd;
  logic [T_W-1:0]   t_val;
  logic [T_W-1:0]   c_val;
  logic             cut_fin;
  logic [MM_W:0]    q_rnd;

  always_comb begin
    span     = (far_mm >= near_mm) ? (far_mm - near_mm) : (near_mm - far_mm);
    far_sc   = DEN_W'({far_mm, {DEPTH_BITS{1'b0}}});
    den_calc = far_ge_r ? (far_sc - DEN_W'(prod_r)) : (far_sc + DEN_W'(prod_r));
    // quotient of 2^16 or more is always past the cutoff
    ovf      = DEN_W'({fn_r, {(DEPTH_BITS - MM_W){1'b0}}}) >= den_r;
    take     = rem_r >= dsh_r;
    rem_sub  = rem_r - dsh_r;
    r_low    = rem_r[DEN_W-1:0];
    r_x100   = NUM_W'({r_low, 6'b0}) + NUM_W'({r_low, 5'b0}) + NUM_W'({r_low, 2'b0});
    rnd      = {r_low, 1'b0} >= {1'b0, den_r};
    t_val    = T_W'(q_r) * T_W'(CUT_DEN) + T_W'(a_r);
    c_val    = T_W'(far_mm) * T_W'(CUT_NUM);
    cut_fin  = (t_val > c_val) || ((t_val == c_val) && (rem_r != '0));
    q_rnd    = {1'b0, q_r} + (MM_W + 1)'(round_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      D_IDLE: begin
        if (start) state_nxt = D_MULA;
      end
      D_MULA:  state_nxt = D_MULB;
      D_MULB:  state_nxt = D_CHECK;
      D_CHECK: begin
        state_nxt = ((den_r == '0) || ovf) ? D_IDLE : D_QUO;
      end
      D_QUO: begin
        if (cnt_r == '0) state_nxt = D_FRAC_INIT;
      end
      D_FRAC_INIT: state_nxt = D_FRAC;
      D_FRAC: begin
        if (cnt_r == '0) state_nxt = D_FINAL;
      end
      D_FINAL: state_nxt = D_IDLE;
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        D_IDLE: begin
          if (start) code_r <= code;
        end
        D_MULA: begin
          far_ge_r <= far_mm >= near_mm;
          prod_r   <= span * code_r;
        end
        D_MULB: begin
          fn_r  <= far_mm * near_mm;
          den_r <= den_calc;
        end
        D_CHECK: begin
          if ((den_r == '0) || ovf) begin
            cut_r   <= 1'b1;
            depth_r <= '0;
            done_r  <= 1'b1;
          end else begin
            rem_r <= NUM_W'({fn_r, {DEPTH_BITS{1'b0}}});
            dsh_r <= NUM_W'({den_r, {(MM_W - 1){1'b0}}});
            cnt_r <= CNT_W'(MM_W - 1);
          end
        end
        D_QUO: begin
          if (take) rem_r <= rem_sub;
          q_r   <= {q_r[MM_W-2:0], take};
          dsh_r <= dsh_r >> 1;
          cnt_r <= cnt_r - 1'b1;
        end
        D_FRAC_INIT: begin
          // second pass finds floor(100 * r / den) and its remainder
          rem_r   <= r_x100;
          dsh_r   <= NUM_W'({den_r, {(FRAC_W - 1){1'b0}}});
          round_r <= rnd;
          cnt_r   <= CNT_W'(FRAC_W - 1);
        end
        D_FRAC: begin
          if (take) rem_r <= rem_sub;
          a_r   <= {a_r[FRAC_W-2:0], take};
          dsh_r <= dsh_r >> 1;
          cnt_r <= cnt_r - 1'b1;
        end
        D_FINAL: begin
          cut_r   <= cut_fin;
          depth_r <= cut_fin ? '0 : (q_rnd[MM_W] ? '1 : q_rnd[MM_W-1:0]);
          done_r  <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign res.done  = done_r;
  assign res.cut   = cut_r;
  assign res.depth = depth_r;

endmodule

// File: design/dlmb_frame.sv
module dlmb_frame #(
  parameter int MAX_DIM = dlmb_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [dlmb_pkg::CFG_DIM_W-1:0] image_width,
  input  logic [dlmb_pkg::CFG_DIM_W-1:0] image_height,
  input  dlmb_pkg::frm_ctl_t             ctl,
  output logic                           frame_end,
  output dlmb_pkg::box_t                 box
);
  import dlmb_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM);
  localparam int EFF_W = $clog2(MAX_DIM + 1);

  function automatic logic [EFF_W-1:0] eff_dim(input logic [CFG_DIM_W-1:0] v);
    logic [EFF_W-1:0] d;
    if (v == '0) begin
      d = EFF_W'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      d = EFF_W'(MAX_DIM);
    end else begin
      d = EFF_W'(v);
    end
    return d;
  endfunction

  logic [DIM_W-1:0] col_r, row_r;
  logic [DIM_W-1:0] min_col_r, max_col_r, min_row_r, max_row_r;
  logic             any_r;
  box_t             box_r;

  logic [EFF_W-1:0] w, h, col_inc, row_inc;
  logic             col_wrap, row_wrap;
  logic [DIM_W-1:0] min_col_u, max_col_u, min_row_u, max_row_u;
  logic             any_u;
  box_t             box_nxt;

  always_comb begin
    w        = eff_dim(image_width);
    h        = eff_dim(image_height);
    col_inc  = EFF_W'(col_r) + EFF_W'(1);
    row_inc  = EFF_W'(row_r) + EFF_W'(1);
    col_wrap = !(col_inc < w);
    row_wrap = !(row_inc < h);
    frame_end = col_wrap && row_wrap;

    min_col_u = (ctl.masked && (col_r < min_col_r)) ? col_r : min_col_r;
    max_col_u = (ctl.masked && (col_r > max_col_r)) ? col_r : max_col_r;
    min_row_u = (ctl.masked && (row_r < min_row_r)) ? row_r : min_row_r;
    max_row_u = (ctl.masked && (row_r > max_row_r)) ? row_r : max_row_r;
    any_u     = any_r || ctl.masked;

    // widen by one, clamp to the image
    box_nxt = '0;
    box_nxt.found = any_u;
    if (any_u) begin
      box_nxt.box_left   = BOX_W'((min_col_u != '0) ? (min_col_u - 1'b1) : '0);
      box_nxt.box_top    = BOX_W'((min_row_u != '0) ? (min_row_u - 1'b1) : '0);
      box_nxt.box_right  = BOX_W'((EFF_W'(max_col_u) < (w - 1'b1)) ?
                                  (EFF_W'(max_col_u) + 1'b1) : (w - 1'b1));
      box_nxt.box_bottom = BOX_W'((EFF_W'(max_row_u) < (h - 1'b1)) ?
                                  (EFF_W'(max_row_u) + 1'b1) : (h - 1'b1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      min_col_r <= DIM_W'(MAX_DIM - 1);
      max_col_r <= '0;
      min_row_r <= DIM_W'(MAX_DIM - 1);
      max_row_r <= '0;
      any_r     <= 1'b0;
    end else if (ctl.step) begin
      if (frame_end) begin
        box_r     <= box_nxt;
        col_r     <= '0;
        row_r     <= '0;
        min_col_r <= DIM_W'(MAX_DIM - 1);
        max_col_r <= '0;
        min_row_r <= DIM_W'(MAX_DIM - 1);
        max_row_r <= '0;
        any_r     <= 1'b0;
      end else begin
        col_r     <= col_wrap ? '0 : DIM_W'(col_inc);
        if (col_wrap) row_r <= DIM_W'(row_inc);
        min_col_r <= min_col_u;
        max_col_r <= max_col_u;
        min_row_r <= min_row_u;
        max_row_r <= max_row_u;
        any_r     <= any_u;
      end
    end
  end

  assign box = box_r;

endmodule

// File: design/depth_linearize_mask_bbox.sv
// channel  direction  handshake          payload
// in       into       in_valid/in_stall  in_depth_code
// out      out of     out_valid/out_stall out_is_box, out_depth_mm, out_in_mask,
//                                         out_box_*, out_box_found, out_last
// cfg      into       cfg_wr_en          cfg_index, cfg_wdata
//
// one pixel at a time: a new pixel is accepted only after the last one is handed to
// the output register; the bit-serial divider takes 16 quotient steps plus 7 steps
// for the cutoff fraction, which a pixel found past the cutoff early (zero denominator
// or quotient of 2^16 or more) skips; the frame's last pixel is followed by the box word
// reset is synchronous and restores the register defaults and an empty frame
// the finished word waits in the output register under out_stall while in_stall
// stays high until the core has handed its result over

module depth_linearize_mask_bbox #(
  parameter int MAX_DIM = dlmb_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dlmb_pkg::DEPTH_BITS-1:0] in_depth_code,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_is_box,
  output logic [dlmb_pkg::MM_W-1:0]       out_depth_mm,
  output logic                            out_in_mask,
  output logic [dlmb_pkg::BOX_W-1:0]      out_box_left,
  output logic [dlmb_pkg::BOX_W-1:0]      out_box_right,
  output logic [dlmb_pkg::BOX_W-1:0]      out_box_top,
  output logic [dlmb_pkg::BOX_W-1:0]      out_box_bottom,
  output logic                            out_box_found,
  output logic                            out_last,
  input  logic                            cfg_wr_en,
  input  logic [dlmb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dlmb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import dlmb_pkg::*;

  top_state_t state_r, state_nxt;

  logic [CFG_DIM_W-1:0] image_width_r, image_height_r;
  logic [MM_W-1:0]      near_mm_r, far_mm_r;

  logic             out_valid_r;
  logic             out_is_box_r;
  logic [MM_W-1:0]  out_depth_r;
  logic             out_in_mask_r;
  box_t             out_box_r;
  logic             out_last_r;

  logic     out_free;
  logic     div_start;
  logic     load_pix;
  logic     load_box;
  div_res_t div_res;
  frm_ctl_t frm_ctl;
  logic     frame_end;
  box_t     box;

  dlmb_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .code    (in_depth_code),
    .near_mm (near_mm_r),
    .far_mm  (far_mm_r),
    .res     (div_res)
  );

  dlmb_frame #(
    .MAX_DIM (MAX_DIM)
  ) u_frame (
    .clk          (clk),
    .rst_n        (rst_n),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .ctl          (frm_ctl),
    .frame_end    (frame_end),
    .box          (box)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WIDTH_RST;
      image_height_r <= HEIGHT_RST;
      near_mm_r      <= NEAR_RST;
      far_mm_r       <= FAR_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[CFG_DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[CFG_DIM_W-1:0];
        REG_NEAR_MM:      near_mm_r      <= cfg_wdata[MM_W-1:0];
        REG_FAR_MM:       far_mm_r       <= cfg_wdata[MM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    out_free       = !out_valid_r || !out_stall;
    in_stall       = 1'b1;
    div_start      = 1'b0;
    load_pix       = 1'b0;
    load_box       = 1'b0;
    case (state_r)
      T_IDLE: begin
        in_stall  = 1'b0;
        div_start = in_valid;
        if (in_valid) state_nxt = T_CALC;
      end
      T_CALC: begin
        if (div_res.done) state_nxt = T_PIXEL;
      end
      T_PIXEL: begin
        if (out_free) begin
          load_pix  = 1'b1;
          state_nxt = frame_end ? T_BOX : T_IDLE;
        end
      end
      T_BOX: begin
        if (out_free) begin
          load_box  = 1'b1;
          state_nxt = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
    frm_ctl.step   = load_pix;
    frm_ctl.masked = !div_res.cut;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_pix) begin
      out_valid_r   <= 1'b1;
      out_is_box_r  <= 1'b0;
      out_depth_r   <= div_res.depth;
      out_in_mask_r <= !div_res.cut;
      out_box_r     <= '0;
      out_last_r    <= !frame_end;
    end else if (load_box) begin
      out_valid_r   <= 1'b1;
      out_is_box_r  <= 1'b1;
      out_depth_r   <= '0;
      out_in_mask_r <= 1'b0;
      out_box_r     <= box;
      out_last_r    <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_is_box     = out_is_box_r;
  assign out_depth_mm   = out_depth_r;
  assign out_in_mask    = out_in_mask_r;
  assign out_box_left   = out_box_r.box_left;
  assign out_box_right  = out_box_r.box_right;
  assign out_box_top    = out_box_r.box_top;
  assign out_box_bottom = out_box_r.box_bottom;
  assign out_box_found  = out_box_r.found;
  assign out_last       = out_last_r;

endmodule

// File: design/dlmb_checker.sv
module dlmb_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      out_is_box,
  input logic [dlmb_pkg::MM_W-1:0] out_depth_mm,
  input logic                      out_in_mask,
  input logic                      out_last
);

  // one pixel in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a pixel is in flight");

  // a pixel word not marked last is followed by the box word
  a_box_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_is_box && !out_last |=> out_valid && out_is_box)
    else $error("frame end pixel not followed by box word");

  a_box_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_box |-> out_last && !out_in_mask && (out_depth_mm == '0))
    else $error("box word carries pixel fields");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_depth_mm) && $stable(out_is_box))
    else $error("stalled output word changed");

endmodule

bind depth_linearize_mask_bbox dlmb_checker u_dlmb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_is_box   (out_is_box),
  .out_depth_mm (out_depth_mm),
  .out_in_mask  (out_in_mask),
  .out_last     (out_last)
);
